FILE: rtl/xsh_pkg.sv
// shared types, constants and lane functions of the four-lane xoshiro256++ core
// depends on nothing; used by every other file of the block but the two channel interfaces
package xsh_pkg;

	localparam int WORD_W     = 64;
	localparam int LANE_IDX_W = 3;
	localparam int BIT_IDX_W  = 8;

	localparam logic [1:0] CMD_NEXT = 2'd0;
	localparam logic [1:0] CMD_SEED = 2'd1;
	localparam logic [1:0] CMD_LOAD = 2'd2;
	localparam logic [1:0] CMD_READ = 2'd3;

	localparam logic [63:0] LCG_MUL = 64'h5851_f42d_4c95_7f2d;
	localparam logic [63:0] LCG_ADD = 64'h1405_7b7e_f767_814f;

	localparam logic [255:0] JUMP_POLY = {
		64'h39ab_dc45_29b1_661c, 64'ha958_2618_e03f_c9aa,
		64'hd5a6_1266_f0c9_392c, 64'h180e_c6d3_3cfd_0aba
	};

	localparam logic [63:0] RESET_TABLE [16] = '{
		64'hd5a9_86ae_75c9_a33b, 64'h1016_d8e3_483a_8f0f,
		64'h81f9_e626_0eb8_e5df, 64'hfa9b_718d_8d07_69bf,
		64'h7778_8d12_d7c3_f90a, 64'h8480_d040_1b60_cca6,
		64'h84b0_c73f_9296_7168, 64'h699d_3c09_7d2a_746d,
		64'h9bb2_5b5d_4797_5e04, 64'h7a98_b60b_cc8d_9aac,
		64'hdea3_ef04_2916_16cd, 64'had69_44fe_d639_d10b,
		64'ha3aa_7908_8ad4_f6e6, 64'hfe26_edc7_83fd_076a,
		64'hc59a_a1a5_97d9_ccc7, 64'h9937_52ab_8d4d_5eba
	};

	typedef logic [3:0][WORD_W-1:0] lane_t;

	typedef struct packed {
		logic                  step_all;
		logic                  load_words;
		logic                  seed_latch;
		logic                  mul_en;
		logic [1:0]            mul_phase;
		logic [1:0]            seed_word;
		logic                  jump_load;
		logic                  jump_run;
		logic                  jump_store;
		logic [BIT_IDX_W-1:0]  jump_bit;
		logic [LANE_IDX_W-1:0] src_lane;
		logic [LANE_IDX_W-1:0] dst_lane;
		logic                  emit;
		logic                  emit_from_lane0;
		logic [LANE_IDX_W-1:0] emit_idx;
		logic                  emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	function automatic lane_t reset_lane(input int k);
		lane_t r;
		r = '0;
		if (k < 4) begin
			r[0] = RESET_TABLE[k * 4];
			r[1] = RESET_TABLE[k * 4 + 1];
			r[2] = RESET_TABLE[k * 4 + 2];
			r[3] = RESET_TABLE[k * 4 + 3];
		end
		return r;
	endfunction

	function automatic lane_t advance(input lane_t s);
		lane_t            n;
		logic [WORD_W-1:0] t;
		t = s[1] << 17;
		n = s;
		n[2] = n[2] ^ n[0];
		n[3] = n[3] ^ n[1];
		n[1] = n[1] ^ n[2];
		n[0] = n[0] ^ n[3];
		n[2] = n[2] ^ t;
		n[3] = {n[3][18:0], n[3][63:19]};
		return n;
	endfunction

	function automatic logic [WORD_W-1:0] out_word(input lane_t s);
		logic [WORD_W-1:0] sum;
		sum = s[0] + s[3];
		return {sum[40:0], sum[63:41]} + s[0];
	endfunction

endpackage

FILE: rtl/xsh_cmd_if.sv
// request channel of the xoshiro256++ core: command and seed or lane words
// depends on nothing
interface xsh_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [63:0] seed_value;
	logic [63:0] word_zero;
	logic [63:0] word_one;
	logic [63:0] word_two;
	logic [63:0] word_three;

	modport source (
		output valid, cmd, seed_value, word_zero, word_one, word_two, word_three,
		input  ready
	);
	modport sink (
		input  valid, cmd, seed_value, word_zero, word_one, word_two, word_three,
		output ready
	);
endinterface

FILE: rtl/xsh_res_if.sv
// result channel of the xoshiro256++ core: one 64-bit word with a last flag
// depends on nothing
interface xsh_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic        last;

	modport source (output valid, value, last, input ready);
	modport sink (input valid, value, last, output ready);
endinterface

FILE: rtl/xsh_datapath.sv
// lane registers, jump engine, lcg multiplier and output register
// depends on xsh_pkg; driven by xsh_ctrl through xsh_pkg::dp_cmd_t
module xsh_datapath #(
	parameter int LANES = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  xsh_pkg::dp_cmd_t   cmd,
	output xsh_pkg::dp_stat_t  stat,
	input  logic [63:0]        seed_value,
	input  logic [63:0]        word_zero,
	input  logic [63:0]        word_one,
	input  logic [63:0]        word_two,
	input  logic [63:0]        word_three,
	input  logic               cfg_we,
	input  logic [63:0]        cfg_wdata,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [63:0]        res_value,
	output logic               res_last
);

	localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

	xsh_pkg::lane_t    lane_q [LANES];
	logic [63:0]       out_buf_q [LANES];
	xsh_pkg::lane_t    t_q;
	xsh_pkg::lane_t    acc_q;
	logic [63:0]       fallback_q;
	logic [63:0]       v_q;
	logic [63:0]       prod_q;
	logic [63:0]       mac_q;
	logic [63:0]       lcg_next;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic              valid_q;
	logic [63:0]       value_q;
	logic              last_q;
	logic [63:0]       emit_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_q <= '0;
		end else if (cfg_we) begin
			fallback_q <= cfg_wdata;
		end
	end

	// lcg: one 32x32 partial product per cycle
	always_comb begin
		mul_a = v_q[31:0];
		mul_b = xsh_pkg::LCG_MUL[31:0];
		case (cmd.mul_phase)
			2'd1: begin
				mul_a = v_q[63:32];
			end
			2'd2: begin
				mul_b = xsh_pkg::LCG_MUL[63:32];
			end
			default: begin
			end
		endcase
	end

	assign lcg_next = mac_q + {prod_q[31:0], 32'd0};

	always_ff @(posedge clk) begin
		if (cmd.seed_latch) begin
			v_q <= (seed_value == 64'd0) ? fallback_q : seed_value;
		end else if (cmd.mul_en && cmd.mul_phase == 2'd3) begin
			v_q <= lcg_next;
		end
		if (cmd.mul_en) begin
			prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
			case (cmd.mul_phase)
				2'd0: begin
					mac_q <= xsh_pkg::LCG_ADD;
				end
				2'd1: begin
					mac_q <= mac_q + prod_q;
				end
				default: begin
					mac_q <= lcg_next;
				end
			endcase
		end
	end

	// jump engine
	always_ff @(posedge clk) begin
		if (cmd.jump_load) begin
			t_q   <= lane_q[cmd.src_lane[LANE_W-1:0]];
			acc_q <= '0;
		end else if (cmd.jump_run) begin
			t_q <= xsh_pkg::advance(t_q);
			if (xsh_pkg::JUMP_POLY[cmd.jump_bit]) begin
				acc_q <= acc_q ^ t_q;
			end
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lane_q[k] <= xsh_pkg::reset_lane(k);
			end else if (cmd.step_all) begin
				lane_q[k] <= xsh_pkg::advance(lane_q[k]);
			end else if (cmd.jump_store && cmd.dst_lane == xsh_pkg::LANE_IDX_W'(k)) begin
				lane_q[k] <= acc_q;
			end else if (k == 0 && cmd.load_words) begin
				lane_q[k] <= {word_three, word_two, word_one, word_zero};
			end else if (k == 0 && cmd.mul_en && cmd.mul_phase == 2'd3) begin
				lane_q[k][cmd.seed_word] <= lcg_next;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.step_all) begin
				out_buf_q[k] <= xsh_pkg::out_word(lane_q[k]);
			end
		end
	end

	assign emit_value = cmd.emit_from_lane0 ? lane_q[0][cmd.emit_idx[1:0]]
		: out_buf_q[cmd.emit_idx[LANE_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q <= emit_value;
			last_q  <= cmd.emit_last;
		end
	end

	assign stat.out_free = !valid_q || res_ready;
	assign res_valid     = valid_q;
	assign res_value     = value_q;
	assign res_last      = last_q;

endmodule

FILE: rtl/xsh_ctrl.sv
// command sequencer: request handshake, emit, seed and jump sequencing
// depends on xsh_pkg; commands xsh_datapath through xsh_pkg::dp_cmd_t
module xsh_ctrl #(
	parameter int LANES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_cmd,
	input  xsh_pkg::dp_stat_t stat,
	output xsh_pkg::dp_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EMIT   = 3'd1;
	localparam logic [2:0] ST_SEED   = 3'd2;
	localparam logic [2:0] ST_JLOAD  = 3'd3;
	localparam logic [2:0] ST_JRUN   = 3'd4;
	localparam logic [2:0] ST_JSTORE = 3'd5;

	localparam logic [2:0] ST_RESET = (LANES > 4) ? ST_JLOAD : ST_IDLE;
	localparam logic [xsh_pkg::LANE_IDX_W-1:0] LAST_LANE = xsh_pkg::LANE_IDX_W'(LANES - 1);
	localparam logic [xsh_pkg::LANE_IDX_W-1:0] DST_RESET =
		(LANES > 4) ? xsh_pkg::LANE_IDX_W'(4) : xsh_pkg::LANE_IDX_W'(1);

	logic [2:0]                          state_q;
	logic [xsh_pkg::LANE_IDX_W-1:0]      idx_q;
	logic [xsh_pkg::LANE_IDX_W-1:0]      last_idx_q;
	logic                                from_lane0_q;
	logic [xsh_pkg::LANE_IDX_W-1:0]      dst_q;
	logic [xsh_pkg::BIT_IDX_W-1:0]       bit_q;
	logic [1:0]                          phase_q;
	logic [1:0]                          word_q;
	logic                                take;
	logic                                emit_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign take      = in_valid && in_ready;
	assign emit_last = (idx_q == last_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RESET;
			idx_q        <= '0;
			last_idx_q   <= '0;
			from_lane0_q <= 1'b0;
			dst_q        <= DST_RESET;
			bit_q        <= '0;
			phase_q      <= '0;
			word_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						idx_q   <= '0;
						phase_q <= '0;
						word_q  <= '0;
						dst_q   <= xsh_pkg::LANE_IDX_W'(1);
						case (in_cmd)
							xsh_pkg::CMD_NEXT: begin
								state_q      <= ST_EMIT;
								last_idx_q   <= LAST_LANE;
								from_lane0_q <= 1'b0;
							end
							xsh_pkg::CMD_READ: begin
								state_q      <= ST_EMIT;
								last_idx_q   <= xsh_pkg::LANE_IDX_W'(3);
								from_lane0_q <= 1'b1;
							end
							xsh_pkg::CMD_SEED: begin
								state_q <= ST_SEED;
							end
							default: begin
								state_q <= (LANES > 1) ? ST_JLOAD : ST_IDLE;
							end
						endcase
					end
				end
				ST_EMIT: begin
					if (stat.out_free) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_SEED: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == 2'd3) begin
						word_q <= word_q + 1'b1;
						if (word_q == 2'd3) begin
							state_q <= (LANES > 1) ? ST_JLOAD : ST_IDLE;
						end
					end
				end
				ST_JLOAD: begin
					bit_q   <= '0;
					state_q <= ST_JRUN;
				end
				ST_JRUN: begin
					bit_q <= bit_q + 1'b1;
					if (&bit_q) begin
						state_q <= ST_JSTORE;
					end
				end
				ST_JSTORE: begin
					if (dst_q == LAST_LANE) begin
						state_q <= ST_IDLE;
					end else begin
						dst_q   <= dst_q + 1'b1;
						state_q <= ST_JLOAD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd                 = '0;
		cmd.step_all        = take && in_cmd == xsh_pkg::CMD_NEXT;
		cmd.load_words      = take && in_cmd == xsh_pkg::CMD_LOAD;
		cmd.seed_latch      = take && in_cmd == xsh_pkg::CMD_SEED;
		cmd.mul_en          = (state_q == ST_SEED);
		cmd.mul_phase       = phase_q;
		cmd.seed_word       = word_q;
		cmd.jump_load       = (state_q == ST_JLOAD);
		cmd.jump_run        = (state_q == ST_JRUN);
		cmd.jump_store      = (state_q == ST_JSTORE);
		cmd.jump_bit        = bit_q;
		cmd.src_lane        = dst_q - 1'b1;
		cmd.dst_lane        = dst_q;
		cmd.emit            = (state_q == ST_EMIT) && stat.out_free;
		cmd.emit_from_lane0 = from_lane0_q;
		cmd.emit_idx        = idx_q;
		cmd.emit_last       = emit_last;
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("emit while output register is occupied");

	a_next_goes_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_cmd == xsh_pkg::CMD_NEXT) |=> (state_q == ST_EMIT && idx_q == '0))
		else $error("next transaction did not start emitting at lane 0");

	a_store_not_lane0: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.jump_store |-> (dst_q != '0 && dst_q <= LAST_LANE))
		else $error("jump result stored to an invalid lane");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_last) |=> (state_q == ST_IDLE))
		else $error("last result emitted but sequencer did not return to idle");

	a_run_then_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_JRUN && &bit_q) |=> (state_q == ST_JSTORE))
		else $error("jump did not store after its final step");

endmodule

FILE: rtl/xoshiro256pp_four_lane_prng_core.sv
// top level of the multi-lane xoshiro256++ generator
// depends on xsh_pkg, xsh_cmd_if, xsh_res_if, xsh_ctrl and xsh_datapath
//
// channel   | dir | payload                                         | handshake
// request   | in  | cmd, seed_value, word_zero .. word_three         | valid/ready
// result    | out | value, last                                      | valid/ready
// cfg       | in  | cfg_wdata (fallback seed)                        | cfg_we
//
// next: all lanes step when taken, then one result per cycle goes out through the
// output register; a stalled result holds the sequencer. seed: lane 0 through the
// shared 32x32 multiplier, then a jump into each further lane from the one before;
// load: lane 0 from the words, then the same jumps. each jump is 256 steps of one
// lane advance plus a load and a store state. reset: with more than four lanes a
// jump pass into lanes 4 up runs first and no request is taken meanwhile.
module xoshiro256pp_four_lane_prng_core #(
	parameter int LANES = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [63:0]  cfg_wdata,
	xsh_cmd_if.sink      request,
	xsh_res_if.source    result
);

	xsh_pkg::dp_cmd_t  cmd;
	xsh_pkg::dp_stat_t stat;

	xsh_ctrl #(
		.LANES (LANES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (request.ready),
		.in_cmd   (request.cmd),
		.stat     (stat),
		.cmd      (cmd)
	);

	xsh_datapath #(
		.LANES (LANES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.seed_value (request.seed_value),
		.word_zero  (request.word_zero),
		.word_one   (request.word_one),
		.word_two   (request.word_two),
		.word_three (request.word_three),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.res_value  (result.value),
		.res_last   (result.last)
	);

endmodule

FILE: sim/xoshiro256pp_four_lane_prng_core_test.sv
// self-checking testbench of the four-lane xoshiro256++ core: next, seed, load and readback
// commands under random idling on both channels, checked against an in-bench generator model
// depends on xsh_pkg, xsh_cmd_if, xsh_res_if and xoshiro256pp_four_lane_prng_core
module xoshiro256pp_four_lane_prng_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT  = 5000;
	localparam int SETTLE_CYC  = 1000;
	localparam int RANDOM_CMDS = 34;

	localparam logic [63:0] SEED_MUL = 64'd6364136223846793005;
	localparam logic [63:0] SEED_INC = 64'd1442695040888963407;

	localparam logic [63:0] JUMP_TAPS [4] = '{
		64'h180ec6d33cfd0aba, 64'hd5a61266f0c9392c,
		64'ha9582618e03fc9aa, 64'h39abdc4529b1661c
	};

	localparam logic [63:0] POWER_ON_WORDS [16] = '{
		64'hd5a986ae75c9a33b, 64'h1016d8e3483a8f0f, 64'h81f9e6260eb8e5df, 64'hfa9b718d8d0769bf,
		64'h77788d12d7c3f90a, 64'h8480d0401b60cca6, 64'h84b0c73f92967168, 64'h699d3c097d2a746d,
		64'h9bb25b5d47975e04, 64'h7a98b60bcc8d9aac, 64'hdea3ef04291616cd, 64'had6944fed639d10b,
		64'ha3aa79088ad4f6e6, 64'hfe26edc783fd076a, 64'hc59aa1a597d9ccc7, 64'h993752ab8d4d5eba
	};

	typedef logic [3:0][63:0] gen_words_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] seed;
		logic [63:0] w0;
		logic [63:0] w1;
		logic [63:0] w2;
		logic [63:0] w3;
	} gen_cmd_t;

	typedef struct packed {
		logic [63:0] value;
		logic        last;
	} out_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [63:0] cfg_wdata;

	xsh_cmd_if request_ch ();
	xsh_res_if result_ch ();

	xoshiro256pp_four_lane_prng_core #(
		.LANES(4)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.request(request_ch),
		.result(result_ch)
	);

	gen_words_t  lanes_model [4];
	logic [63:0] fallback_model;

	gen_cmd_t  pending_cmds [$];
	out_word_t due_words [$];

	int fail_count;
	int cmd_seen [4];
	int words_checked;

	gen_cmd_t  drv_item;
	bit        drv_active;
	int        drv_gap;
	int        drv_run;
	int        mon_gap;
	int        mon_run;
	out_word_t mon_want;
	int        idle_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [63:0] rot_left(input logic [63:0] x, input int k);
		return (x << k) | (x >> (64 - k));
	endfunction

	function automatic logic [63:0] mix_output(input gen_words_t q);
		return rot_left(q[0] + q[3], 23) + q[0];
	endfunction

	function automatic gen_words_t step_words(input gen_words_t q);
		logic [63:0] t;
		t = q[1] << 17;
		q[2] = q[2] ^ q[0];
		q[3] = q[3] ^ q[1];
		q[1] = q[1] ^ q[2];
		q[0] = q[0] ^ q[3];
		q[2] = q[2] ^ t;
		q[3] = rot_left(q[3], 45);
		return q;
	endfunction

	function automatic gen_words_t jump_words(input gen_words_t src);
		gen_words_t acc;
		gen_words_t t;
		acc = '0;
		t = src;
		for (int j = 0; j < 4; j++) begin
			for (int b = 0; b < 64; b++) begin
				if (JUMP_TAPS[j][b])
					acc = acc ^ t;
				t = step_words(t);
			end
		end
		return acc;
	endfunction

	function automatic void spread_from_lane0();
		for (int k = 1; k < 4; k++)
			lanes_model[k] = jump_words(lanes_model[k - 1]);
	endfunction

	function automatic void predict_command(input gen_cmd_t c);
		logic [63:0] v;
		out_word_t   o;
		cmd_seen[c.cmd]++;
		case (c.cmd)
			xsh_pkg::CMD_NEXT: begin
				for (int k = 0; k < 4; k++) begin
					o.value = mix_output(lanes_model[k]);
					o.last  = (k == 3);
					due_words.push_back(o);
					lanes_model[k] = step_words(lanes_model[k]);
				end
			end
			xsh_pkg::CMD_SEED: begin
				v = (c.seed != '0) ? c.seed : fallback_model;
				for (int w = 0; w < 4; w++) begin
					v = v * SEED_MUL + SEED_INC;
					lanes_model[0][w] = v;
				end
				spread_from_lane0();
			end
			xsh_pkg::CMD_LOAD: begin
				lanes_model[0] = {c.w3, c.w2, c.w1, c.w0};
				spread_from_lane0();
			end
			default: begin
				for (int w = 0; w < 4; w++) begin
					o.value = lanes_model[0][w];
					o.last  = (w == 3);
					due_words.push_back(o);
				end
			end
		endcase
	endfunction

	function automatic int draw_gap(inout int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			run_left = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void queue_cmd(input logic [1:0] cmd, input logic [63:0] seed,
			input logic [63:0] w0, input logic [63:0] w1,
			input logic [63:0] w2, input logic [63:0] w3);
		gen_cmd_t c;
		c.cmd  = cmd;
		c.seed = seed;
		c.w0   = w0;
		c.w1   = w1;
		c.w2   = w2;
		c.w3   = w3;
		pending_cmds.push_back(c);
	endfunction

	function automatic void queue_random_cmd();
		int          r;
		logic [1:0]  cmd;
		logic [63:0] seed;
		r = $urandom_range(0, 99);
		if (r < 55)
			cmd = xsh_pkg::CMD_NEXT;
		else if (r < 75)
			cmd = xsh_pkg::CMD_READ;
		else if (r < 88)
			cmd = xsh_pkg::CMD_SEED;
		else
			cmd = xsh_pkg::CMD_LOAD;
		seed = ($urandom_range(0, 5) == 0) ? 64'd0 : {$urandom, $urandom};
		queue_cmd(cmd, seed, rand_word(), rand_word(), rand_word(), rand_word());
	endfunction

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || drv_active || due_words.size() != 0);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_fallback(input logic [63:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		fallback_model = v;
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			request_ch.valid <= 1'b0;
			drv_active = 1'b0;
			drv_gap    = 0;
		end else begin
			if (drv_active && request_ch.ready) begin
				predict_command(drv_item);
				drv_active = 1'b0;
				drv_gap    = draw_gap(drv_run);
			end
			if (!drv_active) begin
				if (drv_gap > 0)
					drv_gap--;
				else if (pending_cmds.size() != 0) begin
					drv_item   = pending_cmds.pop_front();
					drv_active = 1'b1;
				end
			end
			request_ch.valid      <= drv_active;
			request_ch.cmd        <= drv_item.cmd;
			request_ch.seed_value <= drv_item.seed;
			request_ch.word_zero  <= drv_item.w0;
			request_ch.word_one   <= drv_item.w1;
			request_ch.word_two   <= drv_item.w2;
			request_ch.word_three <= drv_item.w3;
		end
	end

	// result monitor and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			mon_gap = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				words_checked++;
				if (due_words.size() == 0) begin
					$error("unexpected transaction: value %h last %0d",
						result_ch.value, result_ch.last);
					fail_count++;
				end else begin
					mon_want = due_words.pop_front();
					if (mon_want.value !== result_ch.value) begin
						$error("value: expected %h, actual %h", mon_want.value, result_ch.value);
						fail_count++;
					end
					if (mon_want.last !== result_ch.last) begin
						$error("last: expected %0d, actual %0d", mon_want.last, result_ch.last);
						fail_count++;
					end
				end
				mon_gap = draw_gap(mon_run);
			end
			if (mon_gap > 0) begin
				mon_gap--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on transaction progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d cycles without a transaction", idle_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		request_ch.valid      = 1'b0;
		request_ch.cmd        = xsh_pkg::CMD_NEXT;
		request_ch.seed_value = '0;
		request_ch.word_zero  = '0;
		request_ch.word_one   = '0;
		request_ch.word_two   = '0;
		request_ch.word_three = '0;
		result_ch.ready       = 1'b0;
		fail_count    = 0;
		words_checked = 0;
		idle_cycles   = 0;
		drv_active    = 1'b0;
		drv_gap       = 0;
		drv_run       = 0;
		mon_gap       = 0;
		mon_run       = 0;
		drv_item      = '0;
		for (int i = 0; i < 4; i++)
			cmd_seen[i] = 0;
		for (int k = 0; k < 4; k++)
			for (int w = 0; w < 4; w++)
				lanes_model[k][w] = POWER_ON_WORDS[k * 4 + w];
		fallback_model = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// power-on state, zero fallback, zero and all-ones seeds and words
		write_fallback('0);
		queue_cmd(xsh_pkg::CMD_READ, '1, '1, '1, '1, '1);
		queue_cmd(xsh_pkg::CMD_NEXT, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_NEXT, '1, '1, '1, '1, '1);
		queue_cmd(xsh_pkg::CMD_READ, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_SEED, '0, '1, '1, '1, '1);
		queue_cmd(xsh_pkg::CMD_READ, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_NEXT, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_SEED, '1, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_NEXT, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_SEED, 64'd1, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_READ, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_LOAD, '1, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_NEXT, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_NEXT, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_READ, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_LOAD, '0, '1, '1, '1, '1);
		queue_cmd(xsh_pkg::CMD_NEXT, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_READ, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_LOAD, rand_word(), {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		queue_cmd(xsh_pkg::CMD_NEXT, '0, '0, '0, '0, '0);
		wait_quiet();

		// all-ones fallback behind a zero seed
		write_fallback('1);
		queue_cmd(xsh_pkg::CMD_SEED, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_READ, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_NEXT, '0, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_SEED, {$urandom, $urandom}, '0, '0, '0, '0);
		queue_cmd(xsh_pkg::CMD_NEXT, '0, '0, '0, '0, '0);
		wait_quiet();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_fallback({$urandom, $urandom});
				1: write_fallback(64'd1);
				2: write_fallback('0);
				default: write_fallback({$urandom, $urandom});
			endcase
			for (int i = 0; i < RANDOM_CMDS; i++)
				queue_random_cmd();
			wait_quiet();
		end

		if (due_words.size() != 0) begin
			$error("%0d expected output words never arrived", due_words.size());
			fail_count++;
		end
		$display("ran %0d next, %0d seed, %0d load and %0d readback commands",
			cmd_seen[xsh_pkg::CMD_NEXT], cmd_seen[xsh_pkg::CMD_SEED],
			cmd_seen[xsh_pkg::CMD_LOAD], cmd_seen[xsh_pkg::CMD_READ]);
		$display("checked %0d output words over six fallback seed settings", words_checked);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
